// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the radix text formatter.
// No dependencies; every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/i2rt_pkg.sv =====
// Types, character codes and constant tables for the radix text formatter.
// No dependencies; imported by integer_to_radix_text.
package i2rt_pkg;

	typedef enum logic [1:0] {
		MODE_BIN = 2'd0,
		MODE_DEC = 2'd1,
		MODE_OCT = 2'd2,
		MODE_HEX = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_HASH,
		ST_DEC,
		ST_SKIP,
		ST_DIG,
		ST_SUFFIX
	} state_t;

	localparam int CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CH_MINUS  = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_HASH   = 7'h23;
	localparam logic [CHAR_W-1:0] CH_SUF_B  = 7'h62;
	localparam logic [CHAR_W-1:0] CH_SUF_O  = 7'h6F;
	localparam logic [CHAR_W-1:0] CH_SUF_H  = 7'h68;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA  = 7'h37;

	// Decimal digit positions run from 10^18 down to the units digit.
	localparam int DEC_POS_W = 5;
	localparam logic [DEC_POS_W-1:0] DEC_LAST_POS = 5'd18;

	// One character handed from the sequencer to the pairing stage.
	typedef struct packed {
		logic                req;
		logic [CHAR_W-1:0]   ch;
		logic                fin;
	} char_push_t;

	function automatic logic [63:0] pow10(input logic [DEC_POS_W-1:0] pos);
		logic [63:0] p;
		unique case (pos)
			5'd0:    p = 64'd1000000000000000000;
			5'd1:    p = 64'd100000000000000000;
			5'd2:    p = 64'd10000000000000000;
			5'd3:    p = 64'd1000000000000000;
			5'd4:    p = 64'd100000000000000;
			5'd5:    p = 64'd10000000000000;
			5'd6:    p = 64'd1000000000000;
			5'd7:    p = 64'd100000000000;
			5'd8:    p = 64'd10000000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd100000000;
			5'd11:   p = 64'd10000000;
			5'd12:   p = 64'd1000000;
			5'd13:   p = 64'd100000;
			5'd14:   p = 64'd10000;
			5'd15:   p = 64'd1000;
			5'd16:   p = 64'd100;
			5'd17:   p = 64'd10;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {3'b000, d};
		end else begin
			c = CH_ALPHA + {3'b000, d};
		end
		return c;
	endfunction

endpackage

// ===== rtl/integer_to_radix_text.sv =====
// Formats a signed integer as ASCII text in base 2, 8, 10 or 16, up to two characters per beat.
// Decimal digits come from one compare and subtract of a power of ten per cycle; an output stall
// holds the sequencer whenever its next character needs the output register.
// One number at a time; the next is taken in the cycle after the last beat loads.
// Reset: arst_n clears the sequencer, the held character and the output valid at once.
`include "assert_macros.svh"

module integer_to_radix_text import i2rt_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [63:0]       value,
	input  logic [1:0]        mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] char_first,
	output logic [CHAR_W-1:0] char_second,
	output logic              second_valid,
	output logic              last
);

	// The magnitude register has three spare bits on top so that binary, octal and hex can each align
	// their highest digit group with the register's top.
	localparam int PW    = VALUE_WIDTH + 3;
	localparam int CW    = $clog2(VALUE_WIDTH + 1);
	localparam int POS_B = VALUE_WIDTH - 1;
	localparam int POS_O = ((VALUE_WIDTH - 1) / 3) * 3;
	localparam int POS_H = ((VALUE_WIDTH - 1) / 4) * 4;
	localparam int NG_B  = POS_B + 1;
	localparam int NG_O  = POS_O / 3 + 1;
	localparam int NG_H  = POS_H / 4 + 1;
	localparam int LSH_B = PW - (POS_B + 1);
	localparam int LSH_O = PW - (POS_O + 3);
	localparam int LSH_H = PW - (POS_H + 4);

	state_t                state_q, state_d;
	mode_t                 mode_q;
	mode_t                 mode_in;
	logic [PW-1:0]         mag_q, mag_d;
	logic [DEC_POS_W-1:0]  pos_q, pos_d;
	logic [3:0]            acc_q, acc_d;
	logic                  started_q, started_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  pend_valid_q;
	logic [CHAR_W-1:0]     pend_char_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_first_q, char_second_q;
	logic                  second_valid_q, last_q;

	logic [VALUE_WIDTH-1:0] v_in, abs_in;
	logic                   neg_in;
	logic [63:0]            mag_ext, pow_cur, diff;
	logic                   dec_sub;
	logic [3:0]             top4, grp;
	logic [PW-1:0]          mag_shift;
	char_push_t             push;
	logic                   need_out, slot_free, push_ok, out_load;

	assign mode_in  = mode_t'(mode);
	assign v_in     = value[VALUE_WIDTH-1:0];
	assign neg_in   = v_in[VALUE_WIDTH-1];
	assign abs_in   = neg_in ? (~v_in + 1'b1) : v_in;
	assign in_stall = (state_q != ST_IDLE);

	// Decimal unit: one compare and subtract of the current power of ten.
	assign mag_ext = 64'(mag_q[VALUE_WIDTH-1:0]);
	assign pow_cur = pow10(pos_q);
	assign diff    = mag_ext - pow_cur;
	assign dec_sub = (mag_ext >= pow_cur) && (acc_q != 4'hF);

	assign top4 = mag_q[PW-1 -: 4];

	always_comb begin
		unique case (mode_q)
			MODE_BIN: begin
				grp       = {3'b000, top4[3]};
				mag_shift = mag_q << 1;
			end
			MODE_OCT: begin
				grp       = {1'b0, top4[3:1]};
				mag_shift = mag_q << 3;
			end
			MODE_HEX: begin
				grp       = top4;
				mag_shift = mag_q << 4;
			end
			default: begin
				grp       = top4;
				mag_shift = mag_q;
			end
		endcase
	end

	// Character requested by the sequencer in this cycle.
	always_comb begin
		push = '0;
		unique case (state_q)
			ST_SIGN: push = '{req: 1'b1, ch: CH_MINUS, fin: 1'b0};
			ST_HASH: push = '{req: 1'b1, ch: CH_HASH, fin: 1'b0};
			ST_DEC: begin
				if (pos_q == DEC_LAST_POS) begin
					push = '{req: 1'b1, ch: digit_char(mag_q[3:0]), fin: 1'b1};
				end else if (!dec_sub && (acc_q != 4'd0 || started_q)) begin
					push = '{req: 1'b1, ch: digit_char(acc_q), fin: 1'b0};
				end
			end
			ST_DIG: push = '{req: 1'b1, ch: digit_char(grp), fin: 1'b0};
			ST_SUFFIX: begin
				unique case (mode_q)
					MODE_BIN: push = '{req: 1'b1, ch: CH_SUF_B, fin: 1'b1};
					MODE_OCT: push = '{req: 1'b1, ch: CH_SUF_O, fin: 1'b1};
					default:  push = '{req: 1'b1, ch: CH_SUF_H, fin: 1'b1};
				endcase
			end
			default: push = '0;
		endcase
	end

	// A character that completes a pair, or ends the text, needs the output register.
	assign need_out  = pend_valid_q || push.fin;
	assign slot_free = !out_valid_q || !out_stall;
	assign push_ok   = !push.req || !need_out || slot_free;
	assign out_load  = push.req && need_out && slot_free;

	always_comb begin
		state_d   = state_q;
		mag_d     = mag_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		started_d = started_q;
		cnt_d     = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pos_d     = '0;
					acc_d     = '0;
					started_d = 1'b0;
					unique case (mode_in)
						MODE_BIN: begin
							mag_d = PW'({3'b000, abs_in}) << LSH_B;
							cnt_d = CW'(NG_B);
						end
						MODE_OCT: begin
							mag_d = PW'({3'b000, abs_in}) << LSH_O;
							cnt_d = CW'(NG_O);
						end
						MODE_HEX: begin
							mag_d = PW'({3'b000, abs_in}) << LSH_H;
							cnt_d = CW'(NG_H);
						end
						default: begin
							mag_d = {3'b000, abs_in};
							cnt_d = '0;
						end
					endcase
					if (neg_in) begin
						state_d = ST_SIGN;
					end else if (mode_in == MODE_DEC) begin
						state_d = ST_DEC;
					end else begin
						state_d = ST_HASH;
					end
				end
			end
			ST_SIGN: begin
				if (push_ok) begin
					state_d = (mode_q == MODE_DEC) ? ST_DEC : ST_HASH;
				end
			end
			ST_HASH: begin
				if (push_ok) begin
					state_d = ST_SKIP;
				end
			end
			ST_DEC: begin
				if (pos_q == DEC_LAST_POS) begin
					if (push_ok) begin
						state_d = ST_IDLE;
					end
				end else if (dec_sub) begin
					mag_d = {3'b000, diff[VALUE_WIDTH-1:0]};
					acc_d = acc_q + 4'd1;
				end else if (push_ok) begin
					pos_d     = pos_q + 1'b1;
					acc_d     = '0;
					started_d = started_q || (acc_q != 4'd0);
				end
			end
			ST_SKIP: begin
				// Leading zero groups are dropped, but the lowest group is always printed.
				if (cnt_q > CW'(1) && grp == 4'd0) begin
					mag_d = mag_shift;
					cnt_d = cnt_q - 1'b1;
				end else begin
					state_d = ST_DIG;
				end
			end
			ST_DIG: begin
				if (push_ok) begin
					mag_d = mag_shift;
					cnt_d = cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_d = ST_SUFFIX;
					end
				end
			end
			ST_SUFFIX: begin
				if (push_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			acc_q        <= '0;
			started_q    <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			acc_q     <= acc_d;
			started_q <= started_d;
			cnt_q     <= cnt_d;
			if (out_load) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
				if (push.req && !need_out) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= mag_d;
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode_in;
		end
		if (push.req && !need_out) begin
			pend_char_q <= push.ch;
		end
		if (out_load) begin
			if (pend_valid_q) begin
				char_first_q   <= pend_char_q;
				char_second_q  <= push.ch;
				second_valid_q <= 1'b1;
			end else begin
				char_first_q   <= push.ch;
				char_second_q  <= '0;
				second_valid_q <= 1'b0;
			end
			last_q <= push.fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_first   = char_first_q;
	assign char_second  = char_second_q;
	assign second_valid = second_valid_q;
	assign last         = last_q;

	`ASSERT_CLK(a_accept_starts, in_valid && !in_stall |=> state_q != ST_IDLE, "accepted number did not start")
	`ASSERT_NEVER(a_pend_idle, pend_valid_q && state_q == ST_IDLE, "character held while idle")
	`ASSERT_CLK(a_dec_pos, state_q == ST_DEC |-> pos_q <= DEC_LAST_POS, "decimal position out of range")
	`ASSERT_CLK(a_single_last, out_valid && !second_valid |-> last, "single character beat before end of text")

endmodule
